FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on the rising clock edge, muted while reset is active.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition that must hold at every active clock edge
`define JDTI_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next
`define JDTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define JDTI_ASSERT(label, clk, rst_n, cond)
`define JDTI_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/jdti_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jdti_pkg
// Types, register map, reset values and the control program of the
// joystick dead-zone target integrator.
// ---------------------------------------------------------------------------
package jdti_pkg;

    // Configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd4;

    // Register widths and reset values
    localparam int CFG12_W = 12;
    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 23;
    localparam logic [CFG12_W-1:0] CENTER_RST   = 12'd2048;
    localparam logic [CFG12_W-1:0] DEADZONE_RST = 12'd100;
    localparam logic [GAIN_W-1:0]  GAIN_RST     = 16'd3;
    localparam logic [CFG12_W-1:0] DIVISOR_RST  = 12'd100;
    localparam logic [LIMIT_W-1:0] LIMIT_RST    = 23'd10000;

    // Servo angle: Q8.8 degrees, +/-90 degrees
    localparam int SERVO_W     = 16;
    localparam int SERVO_LIMIT = 23040;

    // Datapath operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_OFFSET = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV    = 3'd4;
    localparam logic [OP_W-1:0] OP_SERVO  = 3'd5;
    localparam logic [OP_W-1:0] OP_STEP   = 3'd6;

    // Jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] COND_NEVER   = 3'd0;
    localparam logic [COND_W-1:0] COND_ALWAYS  = 3'd1;
    localparam logic [COND_W-1:0] COND_NOIN    = 3'd2;
    localparam logic [COND_W-1:0] COND_DIVMORE = 3'd3;
    localparam logic [COND_W-1:0] COND_OUTBUSY = 3'd4;

    // Program addresses
    localparam int PC_W     = 3;
    localparam int PROG_LEN = 8;
    localparam logic [PC_W-1:0] ADDR_LOAD = 3'd0;
    localparam logic [PC_W-1:0] ADDR_DIV  = 3'd3;
    localparam logic [PC_W-1:0] ADDR_WAIT = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } ucode_t;

    // Status seen by the sequencer for its jumps
    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic div_more;
    } seq_stat_t;

    // Control program, one word per step
    localparam ucode_t PROGRAM [0:PROG_LEN-1] = '{
        '{OP_LOAD,   COND_NOIN,    ADDR_LOAD},  // wait for a sample beat
        '{OP_OFFSET, COND_NEVER,   ADDR_LOAD},  // center, dead zone, divider setup
        '{OP_MUL,    COND_NEVER,   ADDR_LOAD},  // X offset times gain
        '{OP_DIV,    COND_DIVMORE, ADDR_DIV},   // one quotient bit per pass
        '{OP_SERVO,  COND_NEVER,   ADDR_LOAD},  // servo integrate and clamp
        '{OP_NOP,    COND_OUTBUSY, ADDR_WAIT},  // hold while the result register is full
        '{OP_STEP,   COND_ALWAYS,  ADDR_LOAD},  // stepper update, publish result
        '{OP_NOP,    COND_ALWAYS,  ADDR_LOAD}   // unused slot
    };

endpackage

FILE: src/joystick_deadzone_target_integrator_core.sv
`timescale 1ns / 1ps
// An accepted input beat passes the offset, multiply, restoring-divide (one
// quotient bit per cycle over MAG_W = max(SAMPLE_BITS, 12) bits), servo and
// stepper steps; a new beat is taken only after the result is published.
// A result waits in its output register while the next item is computed.
// Reset: async active-low; registers to their reset values, targets and
// zero-request history cleared, sequencer at the load step. No clearing pass.
// ---------------------------------------------------------------------------
// joystick_deadzone_target_integrator_core
// Microcoded joystick integrator: dead zone, servo angle integration with a
// +/-90 degree clamp, stepper target integration through an iterative divide.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module joystick_deadzone_target_integrator_core #(
    parameter int SAMPLE_BITS = 12,
    parameter int STEP_BITS   = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // sample channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [SAMPLE_BITS-1:0]           x_sample,
    input  logic [SAMPLE_BITS-1:0]           y_sample,
    input  logic                             zero_request,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [jdti_pkg::SERVO_W-1:0] servo_target,
    output logic signed [STEP_BITS-1:0]      stepper_target,
    output logic                             position_clear,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [jdti_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jdti_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import jdti_pkg::*;

    localparam int IN_W    = (SAMPLE_BITS > CFG12_W) ? SAMPLE_BITS : CFG12_W;
    localparam int OFF_W   = IN_W + 1;
    localparam int MAG_W   = IN_W;
    localparam int CNT_W   = $clog2(MAG_W + 1);
    localparam int PROD_W  = OFF_W + GAIN_W + 1;
    localparam int SSUM_W  = PROD_W + 1;
    localparam int STW_W   = ((STEP_BITS > LIMIT_W + 1) ? STEP_BITS : LIMIT_W + 1) + 1;

    localparam logic signed [SSUM_W-1:0] SRV_HI = SSUM_W'(SERVO_LIMIT);
    localparam logic signed [SSUM_W-1:0] SRV_LO = -SRV_HI;
    localparam logic signed [SERVO_W-1:0] SRV_LIM16 = SERVO_W'(SERVO_LIMIT);
    localparam logic signed [STW_W-1:0] WMAX =
        {{(STW_W-STEP_BITS+1){1'b0}}, {(STEP_BITS-1){1'b1}}};
    localparam logic signed [STW_W-1:0] WMIN = ~WMAX;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG12_W-1:0] center_reg,   center_next;
    logic [CFG12_W-1:0] deadzone_reg, deadzone_next;
    logic [GAIN_W-1:0]  gain_reg,     gain_next;
    logic [CFG12_W-1:0] divisor_reg,  divisor_next;
    logic [LIMIT_W-1:0] limit_reg,    limit_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        center_next   = center_reg;
        deadzone_next = deadzone_reg;
        gain_next     = gain_reg;
        divisor_next  = divisor_reg;
        limit_next    = limit_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CENTER:   center_next   = cfg_data[CFG12_W-1:0];
                REG_DEADZONE: deadzone_next = cfg_data[CFG12_W-1:0];
                REG_GAIN:     gain_next     = cfg_data[GAIN_W-1:0];
                REG_DIVISOR:  divisor_next  = cfg_data[CFG12_W-1:0];
                REG_LIMIT:    limit_next    = cfg_data[LIMIT_W-1:0];
                default:      ; // unmapped index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    ucode_t    ctrl;
    seq_stat_t stat;

    logic [CNT_W-1:0] div_cnt_reg;
    logic             out_valid_reg;

    assign stat.in_valid = in_valid;
    assign stat.out_busy = out_valid_reg && !out_ready;
    assign stat.div_more = (div_cnt_reg != CNT_W'(1));

    jdti_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign in_ready = (ctrl.op == OP_LOAD);

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0]     x_reg, x_next;
    logic [SAMPLE_BITS-1:0]     y_reg, y_next;
    logic                       zr_reg, zr_next;
    logic signed [OFF_W-1:0]    xoff_reg, xoff_next;
    logic                       yneg_reg, yneg_next;
    logic [MAG_W-1:0]           dvd_reg, dvd_next;
    logic [CFG12_W-1:0]         rem_reg, rem_next;
    logic [CNT_W-1:0]           div_cnt_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;

    logic signed [SERVO_W-1:0]   servo_angle_reg, servo_angle_next;
    logic signed [STEP_BITS-1:0] step_target_reg, step_target_next;
    logic                        prev_zr_reg, prev_zr_next;

    logic                        out_valid_next;
    logic signed [SERVO_W-1:0]   out_servo_reg, out_servo_next;
    logic signed [STEP_BITS-1:0] out_step_reg, out_step_next;
    logic                        out_clr_reg, out_clr_next;

    // Center subtraction and dead zone at full precision
    function automatic logic signed [OFF_W-1:0] dz_offset(
        input logic [SAMPLE_BITS-1:0] smp,
        input logic [CFG12_W-1:0]     ctr,
        input logic [CFG12_W-1:0]     dz
    );
        logic signed [OFF_W-1:0] off;
        logic [OFF_W-1:0]        mag;
        begin
            off = $signed({{(OFF_W-SAMPLE_BITS){1'b0}}, smp})
                - $signed({{(OFF_W-CFG12_W){1'b0}}, ctr});
            mag = off[OFF_W-1] ? -off : off;
            if (mag < {{(OFF_W-CFG12_W){1'b0}}, dz})
            begin
                off = '0;
            end
            return off;
        end
    endfunction

    logic signed [OFF_W-1:0]  yoff;
    logic [OFF_W-1:0]         ymag;
    logic [CFG12_W:0]         div_shift;
    logic                     div_fits;
    logic [CFG12_W:0]         div_diff;
    logic signed [SSUM_W-1:0] servo_sum;
    logic signed [SSUM_W-1:0] servo_clamp;
    logic signed [MAG_W:0]    qmag;
    logic signed [MAG_W:0]    dstep;
    logic signed [STW_W-1:0]  step_base;
    logic signed [STW_W-1:0]  step_sum;
    logic signed [STW_W-1:0]  lim_ext;
    logic signed [STW_W-1:0]  step_hi;
    logic signed [STW_W-1:0]  step_lo;
    logic signed [STW_W-1:0]  step_clamp;
    logic                     pclear;

    // Shared arithmetic
    always_comb
    begin
        yoff = dz_offset(y_reg, center_reg, deadzone_reg);
        ymag = yoff[OFF_W-1] ? -yoff : yoff;

        // one restoring-division step
        div_shift = {rem_reg, dvd_reg[MAG_W-1]};
        div_fits  = (div_shift >= {1'b0, divisor_reg});
        div_diff  = div_shift - {1'b0, divisor_reg};

        // servo integrate and clamp
        servo_sum = SSUM_W'(servo_angle_reg) + SSUM_W'(prod_reg);
        if (servo_sum > SRV_HI)
        begin
            servo_clamp = SRV_HI;
        end
        else if (servo_sum < SRV_LO)
        begin
            servo_clamp = SRV_LO;
        end
        else
        begin
            servo_clamp = servo_sum;
        end

        // signed quotient, zero for a zero divisor
        qmag  = $signed({1'b0, dvd_reg});
        dstep = (divisor_reg == '0) ? '0 : (yneg_reg ? -qmag : qmag);

        // stepper: cleared on the falling edge of the request
        pclear    = !zr_reg && prev_zr_reg;
        step_base = pclear ? '0 : STW_W'(step_target_reg);
        step_sum  = step_base + STW_W'(dstep);
        lim_ext   = $signed({{(STW_W-LIMIT_W){1'b0}}, limit_reg});
        if (zr_reg)
        begin
            step_hi = WMAX;
            step_lo = WMIN;
        end
        else
        begin
            step_hi = (lim_ext < WMAX) ? lim_ext : WMAX;
            step_lo = (-lim_ext > WMIN) ? -lim_ext : WMIN;
        end
        if (step_sum > step_hi)
        begin
            step_clamp = step_hi;
        end
        else if (step_sum < step_lo)
        begin
            step_clamp = step_lo;
        end
        else
        begin
            step_clamp = step_sum;
        end
    end

    // Operation decode
    always_comb
    begin
        x_next           = x_reg;
        y_next           = y_reg;
        zr_next          = zr_reg;
        xoff_next        = xoff_reg;
        yneg_next        = yneg_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        div_cnt_next     = div_cnt_reg;
        prod_next        = prod_reg;
        servo_angle_next = servo_angle_reg;
        step_target_next = step_target_reg;
        prev_zr_next     = prev_zr_reg;
        out_servo_next   = out_servo_reg;
        out_step_next    = out_step_reg;
        out_clr_next     = out_clr_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        unique case (ctrl.op)
            OP_NOP:
            begin
            end
            OP_LOAD:
            begin
                if (in_valid)
                begin
                    x_next  = x_sample;
                    y_next  = y_sample;
                    zr_next = zero_request;
                end
            end
            OP_OFFSET:
            begin
                xoff_next    = dz_offset(x_reg, center_reg, deadzone_reg);
                yneg_next    = yoff[OFF_W-1];
                dvd_next     = ymag[MAG_W-1:0];
                rem_next     = '0;
                div_cnt_next = CNT_W'(MAG_W);
            end
            OP_MUL:
            begin
                prod_next = PROD_W'(xoff_reg) * PROD_W'($signed({1'b0, gain_reg}));
            end
            OP_DIV:
            begin
                rem_next     = div_fits ? div_diff[CFG12_W-1:0] : div_shift[CFG12_W-1:0];
                dvd_next     = {dvd_reg[MAG_W-2:0], div_fits};
                div_cnt_next = div_cnt_reg - 1'b1;
            end
            OP_SERVO:
            begin
                servo_angle_next = zr_reg ? '0 : servo_clamp[SERVO_W-1:0];
            end
            OP_STEP:
            begin
                step_target_next = step_clamp[STEP_BITS-1:0];
                prev_zr_next     = zr_reg;
                out_servo_next   = servo_angle_reg;
                out_step_next    = step_clamp[STEP_BITS-1:0];
                out_clr_next     = pclear;
                out_valid_next   = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg      <= CENTER_RST;
            deadzone_reg    <= DEADZONE_RST;
            gain_reg        <= GAIN_RST;
            divisor_reg     <= DIVISOR_RST;
            limit_reg       <= LIMIT_RST;
            servo_angle_reg <= '0;
            step_target_reg <= '0;
            prev_zr_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            center_reg      <= center_next;
            deadzone_reg    <= deadzone_next;
            gain_reg        <= gain_next;
            divisor_reg     <= divisor_next;
            limit_reg       <= limit_next;
            servo_angle_reg <= servo_angle_next;
            step_target_reg <= step_target_next;
            prev_zr_reg     <= prev_zr_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        zr_reg        <= zr_next;
        xoff_reg      <= xoff_next;
        yneg_reg      <= yneg_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        div_cnt_reg   <= div_cnt_next;
        prod_reg      <= prod_next;
        out_servo_reg <= out_servo_next;
        out_step_reg  <= out_step_next;
        out_clr_reg   <= out_clr_next;
    end

    assign out_valid      = out_valid_reg;
    assign servo_target   = out_servo_reg;
    assign stepper_target = out_step_reg;
    assign position_clear = out_clr_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic servo_in_range;
    assign servo_in_range = (servo_target <= SRV_LIM16) && (servo_target >= -SRV_LIM16);

    `JDTI_ASSERT(a_servo_range, clk, rst_n, !out_valid || servo_in_range)
    `JDTI_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
    `JDTI_ASSERT(a_div_count, clk, rst_n, (ctrl.op != OP_DIV) || (div_cnt_reg != '0))

endmodule

FILE: src/jdti_seq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jdti_seq
// Program counter and control store; issues one control word per cycle and
// resolves conditional jumps from datapath status.
// ---------------------------------------------------------------------------
module jdti_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  jdti_pkg::seq_stat_t stat,
    output jdti_pkg::ucode_t   ctrl
);
    import jdti_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    // Control store read
    always_comb
    begin
        ctrl = PROGRAM[pc_reg];
    end

    // Jump resolution
    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEVER:   take = 1'b0;
            COND_ALWAYS:  take = 1'b1;
            COND_NOIN:    take = !stat.in_valid;
            COND_DIVMORE: take = stat.div_more;
            COND_OUTBUSY: take = stat.out_busy;
            default:      take = 1'b0;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ADDR_LOAD;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
